// File: rtl/egg_drop_min_trials_assert.svh
// Assertion macros shared by the egg drop trial modules.
`ifndef EGG_DROP_MIN_TRIALS_ASSERT_SVH
`define EGG_DROP_MIN_TRIALS_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define EDMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent, outside reset.
`define EDMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/edmt_pkg.sv
// Shared types and constants of the egg drop trial block.
package edmt_pkg;

  localparam int FLOORS_W = 8;
  localparam int EGGS_W   = 5;
  localparam int TRIALS_W = 8;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROW0,
    OP_ROW1,
    OP_COL,
    OP_CELL_RD,
    OP_CELL_WR,
    OP_RES_RD,
    OP_OUT
  } edmt_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW0,
    ST_ROW1,
    ST_COL,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_RES_RD,
    ST_RESULT
  } edmt_state_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic last_j;
    logic last_i;
    logic last_x;
    logic f_ge1;
    logic f_ge2;
    logic e_ge2;
    logic out_free;
  } edmt_sts_t;

endpackage

// File: rtl/edmt_ctrl.sv
// Sequencer of the table fill, one query at a time.
module edmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  edmt_pkg::edmt_sts_t sts_i,
  output edmt_pkg::edmt_op_e  op_o
);

  edmt_pkg::edmt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= edmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_d = state_q;
    op_o    = edmt_pkg::OP_NONE;
    unique case (state_q)
      edmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = edmt_pkg::OP_LOAD;
          state_d = edmt_pkg::ST_ROW0;
        end
      end
      edmt_pkg::ST_ROW0: begin
        op_o = edmt_pkg::OP_ROW0;
        if (sts_i.last_j) begin
          state_d = sts_i.f_ge1 ? edmt_pkg::ST_ROW1 : edmt_pkg::ST_COL;
        end
      end
      edmt_pkg::ST_ROW1: begin
        op_o = edmt_pkg::OP_ROW1;
        if (sts_i.last_j) begin
          state_d = edmt_pkg::ST_COL;
        end
      end
      edmt_pkg::ST_COL: begin
        op_o = edmt_pkg::OP_COL;
        if (sts_i.last_i) begin
          state_d = (sts_i.f_ge2 && sts_i.e_ge2) ? edmt_pkg::ST_CELL_RD
                                                  : edmt_pkg::ST_RES_RD;
        end
      end
      edmt_pkg::ST_CELL_RD: begin
        op_o = edmt_pkg::OP_CELL_RD;
        if (sts_i.last_x) begin
          state_d = edmt_pkg::ST_CELL_WR;
        end
      end
      edmt_pkg::ST_CELL_WR: begin
        op_o    = edmt_pkg::OP_CELL_WR;
        state_d = (sts_i.last_j && sts_i.last_i) ? edmt_pkg::ST_RES_RD
                                                 : edmt_pkg::ST_CELL_RD;
      end
      edmt_pkg::ST_RES_RD: begin
        op_o    = edmt_pkg::OP_RES_RD;
        state_d = edmt_pkg::ST_RESULT;
      end
      edmt_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          op_o    = edmt_pkg::OP_OUT;
          state_d = edmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = edmt_pkg::ST_IDLE;
      end
    endcase
  end

  // Take a new query only between queries
  assign in_stall_o = (state_q != edmt_pkg::ST_IDLE);

`include "egg_drop_min_trials_assert.svh"

  `EDMT_ASSERT_IMP(a_out_only_when_free, op_o == edmt_pkg::OP_OUT, sts_i.out_free, "result loaded into busy output")
  `EDMT_ASSERT_IMP(a_cells_need_two_rows, state_q == edmt_pkg::ST_CELL_RD, sts_i.f_ge2 && sts_i.e_ge2, "cell pass without inner entries")
  `EDMT_ASSERT_NEXT(a_load_starts_fill, op_o == edmt_pkg::OP_LOAD, state_q == edmt_pkg::ST_ROW0, "query load did not start the fill")

endmodule

// File: rtl/edmt_dp.sv
// Datapath: loop counters, trial table memory, min-max unit and output register.
module edmt_dp #(
  parameter int MAX_FLOORS = 255,
  parameter int MAX_EGGS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [edmt_pkg::FLOORS_W-1:0]  floors_i,
  input  logic [edmt_pkg::EGGS_W-1:0]    eggs_i,
  input  edmt_pkg::edmt_op_e             op_i,
  output edmt_pkg::edmt_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [edmt_pkg::TRIALS_W-1:0]  trials_o
);

  // Reachable floor and egg counts are bounded by the port widths too
  localparam int FloorLim = (1 << edmt_pkg::FLOORS_W) - 1;
  localparam int EggLim   = (1 << edmt_pkg::EGGS_W) - 1;
  localparam int FloorCap = (MAX_FLOORS < FloorLim) ? MAX_FLOORS : FloorLim;
  localparam int EggCap   = (MAX_EGGS < EggLim) ? MAX_EGGS : EggLim;
  localparam int FW       = $clog2(FloorCap + 1);
  localparam int EW       = $clog2(EggCap + 1);
  localparam int AW       = FW + EW;
  localparam int Depth    = 1 << AW;
  localparam int TW       = edmt_pkg::TRIALS_W;

  logic [TW-1:0] trial_mem [Depth];

  logic [FW-1:0] f_q, f_d, i_q, i_d, x_q, x_d;
  logic [EW-1:0] e_q, e_d, j_q, j_d;
  logic [TW:0]   best_q, best_d;
  logic [TW-1:0] rd_brk_q, rd_stay_q, trials_q;
  logic          rd_valid_q, out_valid_q, out_valid_d;

  logic          wr_en, rd_cell, rd_stay;
  logic [AW-1:0] wr_addr, brk_addr, stay_addr;
  logic [TW-1:0] wr_data, hi_val;
  logic [TW:0]   worst, min_val;

  // Worst case of one drop and running minimum
  assign hi_val  = (rd_brk_q > rd_stay_q) ? rd_brk_q : rd_stay_q;
  assign worst   = {1'b0, hi_val} + {{TW{1'b0}}, 1'b1};
  assign min_val = (worst < best_q) ? worst : best_q;

  // Read addresses: break case, no-break case or final answer
  assign rd_cell   = (op_i == edmt_pkg::OP_CELL_RD);
  assign rd_stay   = rd_cell || (op_i == edmt_pkg::OP_RES_RD);
  assign brk_addr  = {x_q - {{(FW-1){1'b0}}, 1'b1}, j_q - {{(EW-1){1'b0}}, 1'b1}};
  assign stay_addr = (op_i == edmt_pkg::OP_RES_RD) ? {f_q, e_q} : {i_q - x_q, j_q};

  // Write port and counter updates
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {i_q, j_q};
    wr_data = '0;
    f_d     = f_q;
    e_d     = e_q;
    i_d     = i_q;
    j_d     = j_q;
    x_d     = x_q;
    best_d  = best_q;
    if (rd_valid_q) begin
      best_d = min_val;
    end
    unique case (op_i)
      edmt_pkg::OP_LOAD: begin
        if (floors_i > FloorCap[edmt_pkg::FLOORS_W-1:0]) begin
          f_d = FloorCap[FW-1:0];
        end else begin
          f_d = floors_i[FW-1:0];
        end
        if (eggs_i == '0) begin
          e_d = {{(EW-1){1'b0}}, 1'b1};
        end else if (eggs_i > EggCap[edmt_pkg::EGGS_W-1:0]) begin
          e_d = EggCap[EW-1:0];
        end else begin
          e_d = eggs_i[EW-1:0];
        end
        i_d    = '0;
        j_d    = {{(EW-1){1'b0}}, 1'b1};
        best_d = '1;
      end
      edmt_pkg::OP_ROW0: begin
        wr_en   = 1'b1;
        wr_addr = {{FW{1'b0}}, j_q};
        wr_data = '0;
        j_d     = (j_q == e_q) ? {{(EW-1){1'b0}}, 1'b1} : j_q + {{(EW-1){1'b0}}, 1'b1};
      end
      edmt_pkg::OP_ROW1: begin
        wr_en   = 1'b1;
        wr_addr = {{{(FW-1){1'b0}}, 1'b1}, j_q};
        wr_data = {{(TW-1){1'b0}}, 1'b1};
        j_d     = (j_q == e_q) ? {{(EW-1){1'b0}}, 1'b1} : j_q + {{(EW-1){1'b0}}, 1'b1};
      end
      edmt_pkg::OP_COL: begin
        wr_en   = 1'b1;
        wr_addr = {i_q, {{(EW-1){1'b0}}, 1'b1}};
        wr_data = TW'(i_q);
        i_d     = (i_q == f_q) ? FW'(2) : i_q + {{(FW-1){1'b0}}, 1'b1};
        j_d     = EW'(2);
        x_d     = {{(FW-1){1'b0}}, 1'b1};
      end
      edmt_pkg::OP_CELL_RD: begin
        x_d = x_q + {{(FW-1){1'b0}}, 1'b1};
      end
      edmt_pkg::OP_CELL_WR: begin
        // Fold the last drop floor straight into the stored entry
        wr_en   = 1'b1;
        wr_addr = {i_q, j_q};
        wr_data = min_val[TW-1:0];
        x_d     = {{(FW-1){1'b0}}, 1'b1};
        best_d  = '1;
        if (j_q == e_q) begin
          j_d = EW'(2);
          i_d = i_q + {{(FW-1){1'b0}}, 1'b1};
        end else begin
          j_d = j_q + {{(EW-1){1'b0}}, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Trial table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      trial_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_cell) begin
      rd_brk_q <= trial_mem[brk_addr];
    end
    if (rd_stay) begin
      rd_stay_q <= trial_mem[stay_addr];
    end
  end

  // Counters and running minimum
  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    e_q    <= e_d;
    i_q    <= i_d;
    j_q    <= j_d;
    x_q    <= x_d;
    best_q <= best_d;
    if (op_i == edmt_pkg::OP_OUT) begin
      trials_q <= rd_stay_q;
    end
  end

  // Output register hold and read data tracking
  assign out_valid_d = (op_i == edmt_pkg::OP_OUT) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_cell;
      out_valid_q <= out_valid_d;
    end
  end

  // Status to the controller
  assign sts_o.last_j   = (j_q == e_q);
  assign sts_o.last_i   = (i_q == f_q);
  assign sts_o.last_x   = (x_q == i_q);
  assign sts_o.f_ge1    = (f_q != '0);
  assign sts_o.f_ge2    = (f_q > {{(FW-1){1'b0}}, 1'b1});
  assign sts_o.e_ge2    = (e_q > {{(EW-1){1'b0}}, 1'b1});
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign trials_o    = trials_q;

`include "egg_drop_min_trials_assert.svh"

  `EDMT_ASSERT_IMP(a_wr_after_reads, op_i == edmt_pkg::OP_CELL_WR, rd_valid_q, "cell written without last read data")
  `EDMT_ASSERT_IMP(a_drop_in_range, op_i == edmt_pkg::OP_CELL_RD, (x_q != '0) && (x_q <= i_q), "drop floor outside 1..i")
  `EDMT_ASSERT_IMP(a_entry_bounded, op_i == edmt_pkg::OP_CELL_WR, min_val <= (TW+1)'(i_q), "table entry exceeds its floor count")

endmodule

// File: rtl/egg_drop_min_trials.sv
// Top level of the egg drop minimum trials query engine.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+-------------------
//   in      | input     | in_valid_i / in_stall_o | floors_i, eggs_i
//   out     | output    | out_valid_o/out_stall_i | trials_o
//
// One query at a time. With f floors and e eggs (after clamping), the single write
// port of the trial table and one drop floor per cycle through the min-max unit
// set how long a query takes.
// Table contents are not cleared at reset; every query rewrites what it reads.
// The result sits in an output register, so out_stall_i only blocks the next
// result; in_stall_o is high from acceptance until the result is registered.
module egg_drop_min_trials #(
  parameter int MAX_FLOORS = 255,
  parameter int MAX_EGGS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [edmt_pkg::FLOORS_W-1:0] floors_i,
  input  logic [edmt_pkg::EGGS_W-1:0]   eggs_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [edmt_pkg::TRIALS_W-1:0] trials_o
);

  edmt_pkg::edmt_sts_t sts;
  edmt_pkg::edmt_op_e  op;

  // Sequencer
  edmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  // Table, counters and result register
  edmt_dp #(
    .MAX_FLOORS (MAX_FLOORS),
    .MAX_EGGS   (MAX_EGGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .floors_i    (floors_i),
    .eggs_i      (eggs_i),
    .op_i        (op),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .trials_o    (trials_o)
  );

endmodule

// File: verif/egg_drop_min_trials_checker.sv
// Result checker for the egg drop trials block: predicts every query and compares each answer.
module egg_drop_min_trials_checker #(
  parameter int MAX_FLOORS = 255,
  parameter int MAX_EGGS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [edmt_pkg::FLOORS_W-1:0] floors_i,
  input  logic [edmt_pkg::EGGS_W-1:0]   eggs_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [edmt_pkg::TRIALS_W-1:0] trials_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [edmt_pkg::FLOORS_W-1:0] floors;
    logic [edmt_pkg::EGGS_W-1:0]   eggs;
    logic [edmt_pkg::TRIALS_W-1:0] trials;
  } query_rec_t;

  query_rec_t                    answers_q[$];
  query_rec_t                    head_rec;
  query_rec_t                    new_rec;
  logic [edmt_pkg::TRIALS_W-1:0] drop_table [0:MAX_FLOORS][0:MAX_EGGS];
  int                            fails;

  // Fill the scratch table for one query and return the worst-case drop count.
  function automatic logic [edmt_pkg::TRIALS_W-1:0] predict_trials(
    input logic [edmt_pkg::FLOORS_W-1:0] floors_raw,
    input logic [edmt_pkg::EGGS_W-1:0]   eggs_raw
  );
    int f;
    int e;
    int best;
    int brk;
    int stay;
    int worst;
    f = int'(floors_raw);
    e = int'(eggs_raw);
    // Clamp the query to the table size; zero eggs counts as one egg.
    if (f > MAX_FLOORS) f = MAX_FLOORS;
    if (e < 1) e = 1;
    if (e > MAX_EGGS) e = MAX_EGGS;
    // Base rows for every egg count, then the single-egg column.
    for (int j = 1; j <= e; j++) begin
      drop_table[0][j] = '0;
      if (f >= 1) drop_table[1][j] = edmt_pkg::TRIALS_W'(1);
    end
    for (int i = 0; i <= f; i++) begin
      drop_table[i][1] = edmt_pkg::TRIALS_W'(i);
    end
    // Minimize over drop floors the worse of break and no-break outcomes.
    for (int i = 2; i <= f; i++) begin
      for (int j = 2; j <= e; j++) begin
        best = 32'h7fff_ffff;
        for (int x = 1; x <= i; x++) begin
          brk   = int'(drop_table[x-1][j-1]);
          stay  = int'(drop_table[i-x][j]);
          worst = 1 + ((brk > stay) ? brk : stay);
          if (worst < best) best = worst;
        end
        drop_table[i][j] = edmt_pkg::TRIALS_W'(best);
      end
    end
    return drop_table[f][e];
  endfunction

  // Retire answers against the oldest prediction, then queue the new query.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("unexpected result: trials %0d with no query waiting", trials_i);
          end
        end else begin
          head_rec = answers_q.pop_front();
          if (trials_i !== head_rec.trials) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("trials mismatch: floors %0d eggs %0d expected %0d actual %0d",
                       head_rec.floors, head_rec.eggs, head_rec.trials, trials_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        new_rec.floors = floors_i;
        new_rec.eggs   = eggs_i;
        new_rec.trials = predict_trials(floors_i, eggs_i);
        answers_q.push_back(new_rec);
      end
      fail_count_o <= fails;
      pending_o    <= answers_q.size();
    end
  end

endmodule

// File: verif/egg_drop_min_trials_tb.sv
// Testbench top for the egg drop trials block: drives queries and reports the verdict.
module egg_drop_min_trials_tb;

  // Cycle cap, well above a typical run (one full 255x16 table plus stalls).
  localparam int CYCLE_LIMIT = 6_000_000;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [edmt_pkg::FLOORS_W-1:0] floors_i    = '0;
  logic [edmt_pkg::EGGS_W-1:0]   eggs_i      = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [edmt_pkg::TRIALS_W-1:0] trials_o;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int queries_sent  = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 81;

  egg_drop_min_trials uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .floors_i    (floors_i),
    .eggs_i      (eggs_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .trials_o    (trials_o)
  );

  egg_drop_min_trials_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .floors_i     (floors_i),
    .eggs_i       (eggs_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .trials_i     (trials_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Generate the clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result channel at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Present one query, idling first at random, and hold it until accepted.
  task automatic issue_query(input logic [edmt_pkg::FLOORS_W-1:0] f,
                             input logic [edmt_pkg::EGGS_W-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    floors_i   <= f;
    eggs_i     <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queries_sent++;
  endtask

  // Hold off the sender until every answer is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random queries: mostly small tables, a few tall but cheap ones.
  task automatic run_random(input int count);
    logic [edmt_pkg::FLOORS_W-1:0] f;
    logic [edmt_pkg::EGGS_W-1:0]   e;
    int                            pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        f = edmt_pkg::FLOORS_W'($urandom_range(255, 128));
        e = edmt_pkg::EGGS_W'($urandom_range(2, 0));
      end else if (pick < 12) begin
        f = edmt_pkg::FLOORS_W'($urandom_range(255, 0));
        e = edmt_pkg::EGGS_W'($urandom_range(1, 0));
      end else if (pick < 20) begin
        f = edmt_pkg::FLOORS_W'($urandom_range(20, 0));
        e = edmt_pkg::EGGS_W'($urandom_range(31, 17));
      end else begin
        f = edmt_pkg::FLOORS_W'($urandom_range(40, 0));
        e = edmt_pkg::EGGS_W'($urandom_range(16, 1));
      end
      issue_query(f, e);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero and one floor, zero and oversize eggs, full table.
    issue_query(8'd0, 5'd1);
    issue_query(8'd0, 5'd16);
    issue_query(8'd0, 5'd0);
    issue_query(8'd1, 5'd1);
    issue_query(8'd1, 5'd31);
    issue_query(8'd2, 5'd2);
    issue_query(8'd3, 5'd2);
    issue_query(8'd36, 5'd2);
    issue_query(8'd7, 5'd3);
    issue_query(8'd10, 5'd31);
    issue_query(8'd36, 5'd17);
    issue_query(8'd255, 5'd1);
    issue_query(8'd255, 5'd0);
    issue_query(8'd255, 5'd2);
    issue_query(8'd128, 5'd3);
    issue_query(8'd100, 5'd16);
    issue_query(8'd255, 5'd16);
    issue_query(8'd254, 5'd1);
    drain_results();

    // Fast sender against a busy receiver.
    run_random(34);
    drain_results();

    // Swap the idling of the two sides.
    send_idle_pct = 81;
    recv_idle_pct = 14;
    run_random(33);
    drain_results();

    // Back-to-back traffic.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(33);
    drain_results();

    repeat (8) @(posedge clk_i);
    $display("covered %0d queries: corner sizes up to the full 255x16 table, random sizes",
             queries_sent);
    $display("egg codes 0..31 with clamping, three sender/receiver stall mixes, %0d failures",
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/edmt_pkg.sv
rtl/edmt_ctrl.sv
rtl/edmt_dp.sv
rtl/egg_drop_min_trials.sv
verif/egg_drop_min_trials_checker.sv
verif/egg_drop_min_trials_tb.sv
